// ===== hdl/grfsc_pkg.sv =====
// shared types and constants of the frame sync and checksum block
package grfsc_pkg;

   // field widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned EVENT_W    = 3;
   localparam int unsigned LEN_W      = 9;
   localparam int unsigned SUM_W      = 16;
   localparam int unsigned MAXLEN_W   = 13;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned RSP_USER_W = 4;

   // header and length constants
   localparam logic [BYTE_W-1:0]   START_BYTE    = 8'h01;
   localparam logic [BYTE_W-1:0]   ID_CHECK      = 8'hFF;
   localparam logic [LEN_W-1:0]    LEN_EXTRA     = 9'd6;
   localparam logic [LEN_W-1:0]    HDR_END_POS   = 9'd2;
   localparam logic [LEN_W-1:0]    LEN_POS       = 9'd3;
   localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = 13'd4096;

   // event codes carried with every result item
   typedef enum logic [EVENT_W-1:0] {
      EV_NONE    = 3'd0,
      EV_SYNC    = 3'd1,
      EV_LEN_ERR = 3'd2,
      EV_CSUM_BAD = 3'd3,
      EV_GOOD    = 3'd4
   } event_type;

   // one result item before packing
   typedef struct packed {
      logic                in_frame;
      event_type           event_res;
      logic [LEN_W-1:0]    byte_pos;
      logic [BYTE_W-1:0]   byte_value;
      logic [LEN_W-1:0]    frame_len;
      logic [BYTE_W-1:0]   msg_id;
   } rsp_item_type;

endpackage

// ===== hdl/gnss_raw_frame_sync_checksum.sv =====
// frame sync and 16-bit additive checksum deframer, one stream byte per item
//
// Each accepted byte produces exactly one result item in the output register
// in the next cycle; a new byte is accepted every cycle as long as the output
// register is empty or is being taken in the same cycle, so the sustained rate
// is one byte per clock. While hunting, bytes move through a three-byte window
// until start byte 0x01, an id and the id's complement are seen (event sync
// found, position 2). The next byte plus 6 is the frame length; a length above
// max_frame_len gives event length too long and hunting resumes. The last two
// frame bytes are checked, low byte first, against the 16-bit sum of all
// earlier frame bytes and the final byte reports checksum good or bad. The
// window keeps the last header between frames. max_frame_len is written on the
// csr channel, which is always ready, and should only be written while idle.
module gnss_raw_frame_sync_checksum (
   input  logic                             clock,
   input  logic                             reset,
   // input stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [grfsc_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] msg_id, [16:8] frame_len, [24:17] byte_value, [33:25] byte_pos,
   // [39:34] zero
   output logic [grfsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [grfsc_pkg::RSP_USER_W-1:0] rsp_tuser,   // [2:0] event_res, [3] in_frame
   // configuration write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [grfsc_pkg::MAXLEN_W-1:0]   csr_data     // [12:0] max_frame_len
);

   logic [grfsc_pkg::BYTE_W-1:0]   win_ff [3];
   logic [grfsc_pkg::BYTE_W-1:0]   win_in [3];
   logic [grfsc_pkg::LEN_W-1:0]    byte_count_ff, byte_count_in;
   logic [grfsc_pkg::LEN_W-1:0]    frame_length_ff, frame_length_in;
   logic [grfsc_pkg::SUM_W-1:0]    running_sum_ff, running_sum_in;
   logic [grfsc_pkg::BYTE_W-1:0]   checksum_low_ff, checksum_low_in;
   logic [grfsc_pkg::MAXLEN_W-1:0] max_frame_len_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   grfsc_pkg::rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                           accept;
   logic [grfsc_pkg::BYTE_W-1:0]   rx_byte;
   logic [grfsc_pkg::LEN_W-1:0]    flen_cur;
   logic [grfsc_pkg::LEN_W:0]      pos_p1;
   logic [grfsc_pkg::LEN_W:0]      pos_p2;
   logic                           csum_ok;

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rx_byte    = req_tdata[grfsc_pkg::BYTE_W-1:0];

   // length taken from the length byte or from the frame in progress
   assign flen_cur = (byte_count_ff == grfsc_pkg::LEN_POS)
                   ? ({1'b0, rx_byte} + grfsc_pkg::LEN_EXTRA) : frame_length_ff;
   assign pos_p1   = {1'b0, byte_count_ff} + 10'd1;
   assign pos_p2   = {1'b0, byte_count_ff} + 10'd2;
   assign csum_ok  = (running_sum_ff[15:8] == rx_byte) &&
                     (running_sum_ff[7:0] == checksum_low_ff);

   // next state and result item
   always_comb begin
      win_in          = win_ff;
      byte_count_in   = byte_count_ff;
      frame_length_in = frame_length_ff;
      running_sum_in  = running_sum_ff;
      checksum_low_in = checksum_low_ff;

      rsp_item_in            = '0;
      rsp_item_in.event_res  = grfsc_pkg::EV_NONE;
      rsp_item_in.byte_value = rx_byte;

      if (byte_count_ff == '0) begin
         // hunting: shift the window and look for a header
         win_in[0] = win_ff[1];
         win_in[1] = win_ff[2];
         win_in[2] = rx_byte;
         if ((win_ff[1] == grfsc_pkg::START_BYTE) &&
             ((win_ff[2] ^ rx_byte) == grfsc_pkg::ID_CHECK)) begin
            byte_count_in   = grfsc_pkg::LEN_POS;
            frame_length_in = '0;
            running_sum_in  = {8'd0, win_ff[1]} + {8'd0, win_ff[2]} + {8'd0, rx_byte};
            checksum_low_in = '0;
            rsp_item_in.event_res = grfsc_pkg::EV_SYNC;
            rsp_item_in.msg_id    = win_ff[2];
            rsp_item_in.byte_pos  = grfsc_pkg::HDR_END_POS;
         end
      end else begin
         // inside a frame
         frame_length_in      = flen_cur;
         rsp_item_in.msg_id   = win_ff[1];
         rsp_item_in.frame_len = flen_cur;
         rsp_item_in.byte_pos = byte_count_ff;
         rsp_item_in.in_frame = 1'b1;
         if ((byte_count_ff == grfsc_pkg::LEN_POS) &&
             ({4'd0, flen_cur} > max_frame_len_ff)) begin
            byte_count_in         = '0;
            rsp_item_in.event_res = grfsc_pkg::EV_LEN_ERR;
         end else begin
            // sum all bytes before the checksum, catch the low checksum byte
            if (pos_p2 < {1'b0, flen_cur}) begin
               running_sum_in = running_sum_ff + {8'd0, rx_byte};
            end else if (pos_p2 == {1'b0, flen_cur}) begin
               checksum_low_in = rx_byte;
            end
            if (pos_p1 >= {1'b0, flen_cur}) begin
               byte_count_in         = '0;
               rsp_item_in.event_res = csum_ok ? grfsc_pkg::EV_GOOD
                                               : grfsc_pkg::EV_CSUM_BAD;
            end else begin
               byte_count_in = pos_p1[grfsc_pkg::LEN_W-1:0];
            end
         end
      end
   end

   // output register occupancy
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff[0]        <= '0;
         win_ff[1]        <= '0;
         win_ff[2]        <= '0;
         byte_count_ff    <= '0;
         frame_length_ff  <= '0;
         running_sum_ff   <= '0;
         checksum_low_ff  <= '0;
         max_frame_len_ff <= grfsc_pkg::MAX_LEN_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            win_ff          <= win_in;
            byte_count_ff   <= byte_count_in;
            frame_length_ff <= frame_length_in;
            running_sum_ff  <= running_sum_in;
            checksum_low_ff <= checksum_low_in;
         end
         if (csr_valid && csr_ready) begin
            max_frame_len_ff <= csr_data;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_item_ff.byte_pos, rsp_item_ff.byte_value,
                        rsp_item_ff.frame_len, rsp_item_ff.msg_id};
   assign rsp_tuser  = {rsp_item_ff.in_frame, rsp_item_ff.event_res};

endmodule

// ===== hdl/grfsc_checker.sv =====
// port-level checks of the frame sync and checksum block, bound to the top level
module grfsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [grfsc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [grfsc_pkg::RSP_USER_W-1:0] rsp_tuser
);

   logic [grfsc_pkg::EVENT_W-1:0] ev;
   logic                          in_frame;
   logic [grfsc_pkg::BYTE_W-1:0]  msg_id;
   logic [grfsc_pkg::LEN_W-1:0]   frame_len;
   logic [grfsc_pkg::LEN_W-1:0]   byte_pos;
   logic [grfsc_pkg::LEN_W:0]     pos_p1;

   // unpack the result item
   assign ev        = rsp_tuser[2:0];
   assign in_frame  = rsp_tuser[3];
   assign msg_id    = rsp_tdata[7:0];
   assign frame_len = rsp_tdata[16:8];
   assign byte_pos  = rsp_tdata[33:25];
   assign pos_p1    = {1'b0, byte_pos} + 10'd1;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // every accepted item shows up in the output register next cycle
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   // header completion sits at position two outside the frame
   a_sync_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (ev == grfsc_pkg::EV_SYNC) |-> (byte_pos == 9'd2) && !in_frame)
      else $error("sync item has wrong position");

   // plain hunting bytes carry no frame info
   a_hunt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !in_frame && (ev == grfsc_pkg::EV_NONE)
      |-> (byte_pos == '0) && (msg_id == '0) && (frame_len == '0))
      else $error("hunting item carries frame fields");

   // checksum verdict comes on the last byte of the frame
   a_end_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((ev == grfsc_pkg::EV_GOOD) || (ev == grfsc_pkg::EV_CSUM_BAD))
      |-> in_frame && (pos_p1 == {1'b0, frame_len}))
      else $error("checksum verdict not on last frame byte");

endmodule

bind gnss_raw_frame_sync_checksum grfsc_checker u_grfsc_checker (.*);

// ===== sim/gnss_raw_frame_sync_checksum_test.sv =====
// self-checking testbench for the frame sync and checksum deframer
module gnss_raw_frame_sync_checksum_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 100;

   // one result item split into its fields
   typedef struct packed {
      grfsc_pkg::event_type               ev;
      logic [grfsc_pkg::BYTE_W-1:0]       id;
      logic [grfsc_pkg::LEN_W-1:0]        flen;
      logic [grfsc_pkg::BYTE_W-1:0]       value;
      logic [grfsc_pkg::LEN_W-1:0]        pos;
      logic                               in_frame;
   } deframe_result_type;

   // ways a generated frame can be damaged
   typedef enum int {
      FLAW_NONE,
      FLAW_LOW,
      FLAW_HIGH
   } frame_flaw_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [grfsc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [grfsc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [grfsc_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [grfsc_pkg::MAXLEN_W-1:0]   csr_data = '0;

   // stream bytes waiting to be sent and results waiting to be seen
   logic [grfsc_pkg::BYTE_W-1:0] pending_bytes[$];
   deframe_result_type           expected_results[$];

   // deframer state as predicted
   logic [grfsc_pkg::BYTE_W-1:0]   hdr_window[3];
   int unsigned                    frame_pos;
   int unsigned                    frame_total;
   logic [grfsc_pkg::SUM_W-1:0]    frame_sum;
   logic [grfsc_pkg::BYTE_W-1:0]   sum_low_byte;
   logic [grfsc_pkg::MAXLEN_W-1:0] max_len_setting;

   int  error_count = 0;
   int  cycle_count = 0;
   int  results_seen = 0;
   int  bytes_sent = 0;
   int  sync_count = 0;
   int  good_count = 0;
   int  bad_count = 0;
   int  len_err_count = 0;
   int  limit_count = 0;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   bit  quiet_tail = 1'b0;

   gnss_raw_frame_sync_checksum uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // predict the result of one stream byte and advance the deframer state
   function automatic deframe_result_type deframe_byte(logic [grfsc_pkg::BYTE_W-1:0] b);
      deframe_result_type r;
      int unsigned        pos;
      r.ev       = grfsc_pkg::EV_NONE;
      r.id       = '0;
      r.flen     = '0;
      r.value    = b;
      r.pos      = '0;
      r.in_frame = 1'b0;
      // hunting: slide the header window
      if (frame_pos == 0) begin
         hdr_window[0] = hdr_window[1];
         hdr_window[1] = hdr_window[2];
         hdr_window[2] = b;
         if (hdr_window[0] == grfsc_pkg::START_BYTE &&
             (hdr_window[1] ^ hdr_window[2]) == grfsc_pkg::ID_CHECK) begin
            frame_pos    = grfsc_pkg::LEN_POS;
            frame_total  = 0;
            frame_sum    = hdr_window[0] + hdr_window[1] + hdr_window[2];
            sum_low_byte = '0;
            r.ev         = grfsc_pkg::EV_SYNC;
            r.id         = hdr_window[1];
            r.pos        = grfsc_pkg::HDR_END_POS;
         end
         return r;
      end
      pos        = frame_pos;
      r.id       = hdr_window[1];
      r.pos      = pos[grfsc_pkg::LEN_W-1:0];
      r.in_frame = 1'b1;
      // length byte, abort when over the limit
      if (pos == grfsc_pkg::LEN_POS) begin
         frame_total = b + grfsc_pkg::LEN_EXTRA;
         if (frame_total > max_len_setting) begin
            frame_pos = 0;
            r.ev      = grfsc_pkg::EV_LEN_ERR;
            r.flen    = frame_total[grfsc_pkg::LEN_W-1:0];
            return r;
         end
      end
      r.flen = frame_total[grfsc_pkg::LEN_W-1:0];
      if (pos + 2 < frame_total)
         frame_sum = frame_sum + b;
      else if (pos + 2 == frame_total)
         sum_low_byte = b;
      // last byte closes the frame with the checksum verdict
      if (pos + 1 >= frame_total) begin
         r.ev      = (frame_sum[15:8] == b && frame_sum[7:0] == sum_low_byte) ?
                     grfsc_pkg::EV_GOOD : grfsc_pkg::EV_CSUM_BAD;
         frame_pos = 0;
         return r;
      end
      frame_pos = pos + 1;
      return r;
   endfunction

   // queue a complete frame with random payload
   task automatic add_frame(input logic [grfsc_pkg::BYTE_W-1:0] id,
                            input logic [grfsc_pkg::BYTE_W-1:0] len_byte,
                            input frame_flaw_type flaw);
      logic [grfsc_pkg::BYTE_W-1:0] hdr[4];
      logic [grfsc_pkg::SUM_W-1:0]  sum;
      logic [grfsc_pkg::BYTE_W-1:0] b;
      logic [grfsc_pkg::BYTE_W-1:0] lo;
      logic [grfsc_pkg::BYTE_W-1:0] hi;
      hdr = '{grfsc_pkg::START_BYTE, id, ~id, len_byte};
      sum = '0;
      foreach (hdr[i]) begin
         pending_bytes.push_back(hdr[i]);
         sum = sum + hdr[i];
      end
      repeat (len_byte) begin
         b = 8'($urandom);
         pending_bytes.push_back(b);
         sum = sum + b;
      end
      lo = sum[7:0];
      hi = sum[15:8];
      if (flaw == FLAW_LOW)
         lo = lo ^ (8'd1 << $urandom_range(0, 7));
      else if (flaw == FLAW_HIGH)
         hi = hi ^ (8'd1 << $urandom_range(0, 7));
      pending_bytes.push_back(lo);
      pending_bytes.push_back(hi);
   endtask

   // queue about n bytes, mostly frames, some noise and broken headers
   task automatic add_random_traffic(input int n);
      int                           start_size;
      int unsigned                  pick;
      logic [grfsc_pkg::BYTE_W-1:0] id;
      frame_flaw_type               flaw;
      start_size = pending_bytes.size();
      while (pending_bytes.size() - start_size < n) begin
         pick = $urandom_range(0, 99);
         id   = 8'($urandom);
         if (pick < 80) begin
            flaw = FLAW_NONE;
            if ($urandom_range(0, 4) == 0)
               flaw = $urandom_range(0, 1) ? FLAW_LOW : FLAW_HIGH;
            if ($urandom_range(0, 39) == 0)
               add_frame(id, 8'($urandom_range(25, 255)), flaw);
            else
               add_frame(id, 8'($urandom_range(0, 24)), flaw);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 5)) pending_bytes.push_back(8'($urandom));
         end else if (pick < 95) begin
            // complement check fails
            pending_bytes.push_back(grfsc_pkg::START_BYTE);
            pending_bytes.push_back(id);
            pending_bytes.push_back(id ^ 8'(1 << $urandom_range(0, 7)));
         end else begin
            // header and length with the frame cut short
            pending_bytes.push_back(grfsc_pkg::START_BYTE);
            pending_bytes.push_back(id);
            pending_bytes.push_back(~id);
            pending_bytes.push_back(8'($urandom_range(0, 8)));
         end
      end
   endtask

   // wait until every queued byte has been answered
   task automatic drain;
      while (pending_bytes.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_max_len(input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[grfsc_pkg::MAXLEN_W-1:0];
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid       <= 1'b0;
      max_len_setting = value[grfsc_pkg::MAXLEN_W-1:0];
      limit_count++;
   endtask

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(deframe_byte(req_tdata));
            void'(pending_bytes.pop_front());
            bytes_sent++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
               req_gap = $urandom_range(0, 2);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_bytes[0];
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      deframe_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               $display("%0t: result item with nothing expected, tdata %h tuser %h",
                        $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("event_res", want.ev, rsp_tuser[2:0]);
               check_field("in_frame", want.in_frame, rsp_tuser[3]);
               check_field("msg_id", want.id, rsp_tdata[7:0]);
               check_field("frame_len", want.flen, rsp_tdata[16:8]);
               check_field("byte_value", want.value, rsp_tdata[24:17]);
               check_field("byte_pos", want.pos, rsp_tdata[33:25]);
               check_field("pad bits", 0, rsp_tdata[39:34]);
               case (want.ev)
                  grfsc_pkg::EV_SYNC:     sync_count++;
                  grfsc_pkg::EV_GOOD:     good_count++;
                  grfsc_pkg::EV_CSUM_BAD: bad_count++;
                  grfsc_pkg::EV_LEN_ERR:  len_err_count++;
                  default: ;
               endcase
            end
         end
         // one long hold-off so the block backs up into its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && results_seen >= 150 && pending_bytes.size() > 30) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // reset, directed cases, then random traffic under several limits
   initial begin
      hdr_window      = '{default: '0};
      frame_pos       = 0;
      frame_total     = 0;
      frame_sum       = '0;
      sum_low_byte    = '0;
      max_len_setting = grfsc_pkg::MAX_LEN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // hunting noise, shortest frames, window kept between frames
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(grfsc_pkg::START_BYTE);
      add_frame(8'h00, 8'd0, FLAW_NONE);
      add_frame(8'h01, 8'd0, FLAW_LOW);
      // window still holds 01 FE 01 after a single 01: frame with id FE
      pending_bytes.push_back(grfsc_pkg::START_BYTE);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'h01);
      drain();

      // smallest limit: only a zero length byte passes
      write_max_len(6);
      add_frame(8'hFF, 8'd0, FLAW_HIGH);
      pending_bytes.push_back(grfsc_pkg::START_BYTE);
      pending_bytes.push_back(8'h3C);
      pending_bytes.push_back(8'hC3);
      pending_bytes.push_back(8'd1);
      drain();

      // longest frame one over the limit
      write_max_len(260);
      pending_bytes.push_back(grfsc_pkg::START_BYTE);
      pending_bytes.push_back(8'hA5);
      pending_bytes.push_back(8'h5A);
      pending_bytes.push_back(8'hFF);
      drain();

      // longest frame exactly at the limit, then mixed traffic
      write_max_len(261);
      add_frame(8'($urandom), 8'hFF, FLAW_NONE);
      add_random_traffic(30);
      drain();

      write_max_len($urandom_range(6, 40));
      add_random_traffic(85);
      drain();

      write_max_len($urandom_range(6, grfsc_pkg::MAX_LEN_RESET));
      add_random_traffic(85);
      drain();

      // no idling on either side at the end
      write_max_len(grfsc_pkg::MAX_LEN_RESET);
      quiet_tail = 1'b1;
      add_random_traffic(50);
      drain();
      repeat (10) @(posedge clock);

      $display("sent %0d bytes under %0d limit settings, %0d syncs found",
               bytes_sent, limit_count, sync_count);
      $display("frames: %0d good, %0d bad checksum, %0d too long",
               good_count, bad_count, len_err_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
